@@ rtl/pdec_pkg.sv @@
// Shared types, character constants and helper functions for the percent URL decoder.
// Used by every module under rtl; depends on nothing else.
package pdec_pkg;

  localparam logic [7:0]  CH_PERCENT       = 8'h25;
  localparam logic [7:0]  CH_PLUS          = 8'h2B;
  localparam logic [7:0]  CH_SPACE         = 8'h20;
  localparam logic [11:0] MAX_LENGTH_RESET = 12'd255;

  localparam logic [1:0] HELD_NONE = 2'd0;
  localparam logic [1:0] HELD_ONE  = 2'd1;
  localparam logic [1:0] HELD_TWO  = 2'd2;

  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      count;
    logic            last;
  } group_t;

  // Returns a valid flag and the value of a hex digit of either case.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      // The low nibble of 'A' to 'F' runs from one, so adding nine gives ten upwards.
      r = {1'b1, 4'(c[3:0] + 4'd9)};
    end
    return r;
  endfunction

endpackage

@@ rtl/percent_url_decoder.sv @@
// Top level of the percent URL decoder: configuration register and channel wiring.
// Instantiates pdec_decode and pdec_emit; depends on pdec_pkg.
//
//   Channel   Handshake              Payload
//   config    cfg_valid / cfg_ready  cfg_data (max_length, 12 bits)
//   input     in_valid / in_ready    in_byte, end_of_string
//   output    out_valid / out_ready  out_byte, byte_valid, last_of_string
//
// Each input byte is decoded in the cycle of its transfer and gives zero to three
// results, which leave the result stage one per cycle while out_ready is high. A new
// byte is taken while the result stage is empty or while the last result of the group
// before it is transferred. Reset clears the held escape state, the result stage and
// the length count, and sets max_length to 255. A stalled output holds the input back.
module percent_url_decoder import pdec_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [11:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        end_of_string,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        byte_valid,
  output logic        last_of_string
);

  logic [11:0] max_length;
  group_t      group;
  logic        can_load;
  logic        load;

  assign cfg_ready = 1'b1;
  assign in_ready  = can_load;
  assign load      = in_valid && can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= MAX_LENGTH_RESET;
    end else if (cfg_valid) begin
      max_length <= cfg_data;
    end
  end

  pdec_decode u_decode (
    .clk           (clk),
    .rst           (rst),
    .load          (load),
    .in_byte       (in_byte),
    .end_of_string (end_of_string),
    .group         (group)
  );

  pdec_emit u_emit (
    .clk            (clk),
    .rst            (rst),
    .max_length     (max_length),
    .load           (load),
    .group          (group),
    .can_load       (can_load),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .byte_valid     (byte_valid),
    .last_of_string (last_of_string)
  );

endmodule

@@ rtl/pdec_decode.sv @@
// Escape decoder: holds a pending '%' and first hex digit, and turns each input byte
// into a group of up to three raw result bytes. Depends on pdec_pkg.
module pdec_decode import pdec_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  logic [7:0] in_byte,
  input  logic       end_of_string,
  output group_t     group
);

  logic [1:0] held_count;
  logic [1:0] held_count_next;
  logic [7:0] held_hi;
  logic [7:0] held_hi_next;

  always_comb begin
    logic [4:0] d;
    logic [4:0] h;
    logic       pass;
    logic [1:0] n;
    d               = hex_digit(in_byte);
    h               = hex_digit(held_hi);
    pass            = 1'b1;
    n               = 2'd0;
    group.bytes     = '0;
    held_count_next = held_count;
    held_hi_next    = held_hi;
    if (held_count == HELD_TWO) begin
      if (d[4]) begin
        group.bytes[n]  = {h[3:0], d[3:0]};
        n               = n + 2'd1;
        pass            = 1'b0;
      end else begin
        group.bytes[n]  = CH_PERCENT;
        n               = n + 2'd1;
        group.bytes[n]  = held_hi;
        n               = n + 2'd1;
      end
      held_count_next = HELD_NONE;
    end else if (held_count == HELD_ONE) begin
      if (d[4]) begin
        held_hi_next    = in_byte;
        held_count_next = HELD_TWO;
        pass            = 1'b0;
      end else begin
        group.bytes[n]  = CH_PERCENT;
        n               = n + 2'd1;
        held_count_next = HELD_NONE;
      end
    end else begin
      held_count_next = HELD_NONE;
    end
    if (pass) begin
      if (in_byte == CH_PERCENT) begin
        held_count_next = HELD_ONE;
      end else begin
        group.bytes[n] = (in_byte == CH_PLUS) ? CH_SPACE : in_byte;
        n              = n + 2'd1;
      end
    end
    if (end_of_string) begin
      if (held_count_next != HELD_NONE) begin
        group.bytes[n] = CH_PERCENT;
        n              = n + 2'd1;
      end
      if (held_count_next == HELD_TWO) begin
        group.bytes[n] = held_hi_next;
        n              = n + 2'd1;
      end
      held_count_next = HELD_NONE;
    end
    group.count = n;
    group.last  = end_of_string;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= HELD_NONE;
      held_hi    <= 8'd0;
    end else if (load) begin
      held_count <= held_count_next;
      held_hi    <= held_hi_next;
    end
  end

endmodule

@@ rtl/pdec_emit.sv @@
// Result stage: stores one decoded group and hands out its bytes one per transfer,
// applying the per-string length limit. Depends on pdec_pkg.
module pdec_emit import pdec_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [11:0] max_length,
  input  logic        load,
  input  group_t      group,
  output logic        can_load,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        byte_valid,
  output logic        last_of_string
);

  logic [2:0][7:0] bytes;
  logic [1:0]      count;
  logic [1:0]      idx;
  logic            last;
  logic [11:0]     emitted_count;
  logic            keep;
  logic            final_one;
  logic            transfer;

  assign keep           = emitted_count < max_length;
  assign final_one      = (count == 2'd1);
  assign out_valid      = (count != 2'd0);
  assign transfer       = out_valid && out_ready;
  assign can_load       = (count == 2'd0) || (final_one && out_ready);
  assign out_byte       = keep ? bytes[idx] : 8'd0;
  assign byte_valid     = keep;
  assign last_of_string = last && final_one;

  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= 2'd0;
      idx           <= 2'd0;
      last          <= 1'b0;
      emitted_count <= 12'd0;
    end else begin
      if (load) begin
        count <= group.count;
        idx   <= 2'd0;
        last  <= group.last;
      end else if (transfer) begin
        count <= count - 2'd1;
        idx   <= idx + 2'd1;
      end
      if (transfer) begin
        if (last && final_one) begin
          emitted_count <= 12'd0;
        end else if (keep) begin
          emitted_count <= emitted_count + 12'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes <= group.bytes;
    end
  end

endmodule

@@ tb/tb_percent_url_decoder.sv @@
// Self-checking testbench for percent_url_decoder: a directed table, then random strings.
// Results are compared against the table entries or a behavioural decoder written here; depends on pdec_pkg.
module tb_percent_url_decoder;
  timeunit 1ns;
  timeprecision 1ps;
  import pdec_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       kept;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [7:0]        ch;
    logic              eos;
    logic              typed;
    logic [1:0]        n;
    result_t [2:0]     res;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [11:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte = 8'h61;
  logic        end_of_string = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic        last_of_string;

  logic [11:0] limit_reg = MAX_LENGTH_RESET;
  logic [1:0]  held_n = HELD_NONE;
  logic [7:0]  held_chars [2] = '{8'h00, 8'h00};
  logic [11:0] kept_n = '0;
  result_t     step_res [3];
  int          step_n;

  result_t     due_results [$];
  row_t        table_rows [$];
  row_t        stim_q [$];
  result_t     want_r;
  int          mismatches = 0;
  bit          in_idle_on = 1'b1;
  bit          out_idle_on = 1'b1;

  percent_url_decoder uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_byte(in_byte),
    .end_of_string(end_of_string),
    .out_valid(out_valid), .out_ready(out_ready), .out_byte(out_byte),
    .byte_valid(byte_valid), .last_of_string(last_of_string)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [4:0] hex_of(input logic [7:0] c);
    logic [7:0] t;
    if (c >= "0" && c <= "9") t = c - "0";
    else if (c >= "A" && c <= "F") t = c - "A" + 8'd10;
    else if (c >= "a" && c <= "f") t = c - "a" + 8'd10;
    else return 5'd0;
    return {1'b1, t[3:0]};
  endfunction

  function automatic void emit_char(input logic [7:0] b);
    if (step_n >= 3) return;
    if (kept_n < limit_reg) begin
      step_res[step_n] = '{data: b, kept: 1'b1, last: 1'b0};
      kept_n = kept_n + 12'd1;
    end else begin
      step_res[step_n] = '{data: 8'h00, kept: 1'b0, last: 1'b0};
    end
    step_n++;
  endfunction

  function automatic void take_char(input logic [7:0] c);
    logic [4:0] lo, hi;
    lo = hex_of(c);
    if (held_n == HELD_TWO) begin
      hi = hex_of(held_chars[1]);
      if (lo[4] && hi[4]) begin
        emit_char({hi[3:0], lo[3:0]});
        held_n = HELD_NONE;
        return;
      end
      emit_char(held_chars[0]);
      emit_char(held_chars[1]);
      held_n = HELD_NONE;
    end else if (held_n == HELD_ONE) begin
      if (lo[4]) begin
        held_chars[1] = c;
        held_n = HELD_TWO;
        return;
      end
      emit_char(held_chars[0]);
      held_n = HELD_NONE;
    end
    if (c == CH_PERCENT) begin
      held_chars[0] = c;
      held_n = HELD_ONE;
    end else begin
      emit_char(c == CH_PLUS ? CH_SPACE : c);
    end
  endfunction

  function automatic void decode_item(input logic [7:0] c, input logic eos);
    step_n = 0;
    take_char(c);
    if (eos) begin
      if (held_n == HELD_ONE || held_n == HELD_TWO) emit_char(held_chars[0]);
      if (held_n == HELD_TWO) emit_char(held_chars[1]);
      held_n = HELD_NONE;
      if (step_n > 0) step_res[step_n - 1].last = 1'b1;
      kept_n = '0;
    end
  endfunction

  function automatic result_t mk_result(input logic [7:0] d, input logic k, input logic l);
    return '{data: d, kept: k, last: l};
  endfunction

  function automatic row_t plain_row(input logic [7:0] ch, input logic eos);
    row_t r;
    r = '0;
    r.ch = ch;
    r.eos = eos;
    return r;
  endfunction

  function automatic row_t typed_row(input logic [7:0] ch, input logic eos, input int n,
                                     input result_t r0, input result_t r1, input result_t r2);
    row_t r;
    r = plain_row(ch, eos);
    r.typed = 1'b1;
    r.n = n[1:0];
    r.res[0] = r0;
    r.res[1] = r1;
    r.res[2] = r2;
    return r;
  endfunction

  function automatic logic [7:0] random_hex();
    int r;
    r = $urandom_range(0, 21);
    if (r < 10) return 8'h30 + r[7:0];
    if (r < 16) return 8'h41 + r[7:0] - 8'd10;
    return 8'h61 + r[7:0] - 8'd16;
  endfunction

  function automatic logic [7:0] random_nonhex();
    logic [7:0] c;
    logic [4:0] h;
    do begin
      c = 8'($urandom_range(1, 255));
      h = hex_of(c);
    end while (h[4]);
    return c;
  endfunction

  // Builds one encoded string of one to six pieces and queues it for sending.
  function automatic void add_string();
    logic [7:0] chars [18];
    int m, pieces, k, kind;
    m = 0;
    pieces = $urandom_range(1, 6);
    for (k = 0; k < pieces; k++) begin
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        chars[m] = 8'($urandom_range(1, 255));
        if (chars[m] == CH_PERCENT) chars[m] = "a";
        m++;
      end else if (kind < 60) begin
        chars[m] = CH_PERCENT;
        chars[m + 1] = random_hex();
        chars[m + 2] = random_hex();
        m += 3;
      end else if (kind < 70) begin
        chars[m] = CH_PLUS;
        m++;
      end else if (kind < 75) begin
        chars[m] = CH_PERCENT;
        chars[m + 1] = random_nonhex();
        m += 2;
      end else if (kind < 80) begin
        chars[m] = CH_PERCENT;
        chars[m + 1] = random_hex();
        chars[m + 2] = random_nonhex();
        m += 3;
      end else if (kind < 85) begin
        chars[m] = CH_PERCENT;
        m++;
      end else if (kind < 90) begin
        chars[m] = CH_PERCENT;
        chars[m + 1] = random_hex();
        m += 2;
      end else begin
        chars[m] = 8'($urandom_range(1, 255));
        m++;
      end
    end
    for (k = 0; k < m; k++) stim_q.push_back(plain_row(chars[k], k == m - 1));
  endfunction

  task automatic send_item(input row_t r);
    int i;
    if (in_idle_on) begin
      while ($urandom_range(0, 99) < 36) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_byte <= r.ch;
    end_of_string <= r.eos;
    do @(posedge clk); while (!in_ready);
    decode_item(r.ch, r.eos);
    if (r.typed) begin
      for (i = 0; i < r.n; i++) due_results.push_back(r.res[i]);
    end else begin
      for (i = 0; i < step_n; i++) due_results.push_back(step_res[i]);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_limit(input logic [11:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    limit_reg = v;
  endtask

  always @(posedge clk) begin
    out_ready <= out_idle_on ? ($urandom_range(0, 99) >= 36) : 1'b1;
    if (!rst && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        $error("unexpected result transfer: out_byte %02h, byte_valid %0b, last_of_string %0b",
               out_byte, byte_valid, last_of_string);
        mismatches++;
      end else begin
        want_r = due_results.pop_front();
        if (out_byte !== want_r.data) begin
          $error("out_byte: expected %02h, got %02h", want_r.data, out_byte);
          mismatches++;
        end
        if (byte_valid !== want_r.kept) begin
          $error("byte_valid: expected %0b, got %0b", want_r.kept, byte_valid);
          mismatches++;
        end
        if (last_of_string !== want_r.last) begin
          $error("last_of_string: expected %0b, got %0b", want_r.last, last_of_string);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #5000000;
    $display("percent_url_decoder: mismatch");
    $finish;
  end

  initial begin
    logic [11:0] phase_limit [8];
    int p, i;
    phase_limit = '{12'd0, 12'd1, 12'd3, 12'd4095, 12'd5, 12'd2, 12'd8, 12'd0};
    phase_limit[7] = 12'($urandom_range(0, 12));

    table_rows.push_back(typed_row("a", 1'b0, 1, mk_result("a", 1'b1, 1'b0), '0, '0));
    table_rows.push_back(typed_row(CH_PLUS, 1'b0, 1, mk_result(CH_SPACE, 1'b1, 1'b0),
                                   '0, '0));
    table_rows.push_back(typed_row(CH_PERCENT, 1'b0, 0, '0, '0, '0));
    table_rows.push_back(typed_row("4", 1'b0, 0, '0, '0, '0));
    table_rows.push_back(typed_row("1", 1'b0, 1, mk_result(8'h41, 1'b1, 1'b0), '0, '0));
    table_rows.push_back(typed_row(CH_PERCENT, 1'b0, 0, '0, '0, '0));
    table_rows.push_back(typed_row("f", 1'b0, 0, '0, '0, '0));
    table_rows.push_back(typed_row("F", 1'b0, 1, mk_result(8'hFF, 1'b1, 1'b0), '0, '0));
    table_rows.push_back(typed_row(CH_PERCENT, 1'b0, 0, '0, '0, '0));
    table_rows.push_back(typed_row("0", 1'b0, 0, '0, '0, '0));
    table_rows.push_back(typed_row("0", 1'b0, 1, mk_result(8'h00, 1'b1, 1'b0), '0, '0));
    table_rows.push_back(plain_row(8'h00, 1'b0));
    table_rows.push_back(plain_row(CH_PERCENT, 1'b0));
    table_rows.push_back(plain_row("G", 1'b0));
    table_rows.push_back(plain_row(CH_PERCENT, 1'b0));
    table_rows.push_back(plain_row("a", 1'b0));
    table_rows.push_back(plain_row("x", 1'b0));
    table_rows.push_back(plain_row(CH_PERCENT, 1'b0));
    table_rows.push_back(plain_row("1", 1'b0));
    table_rows.push_back(plain_row(CH_PERCENT, 1'b0));
    table_rows.push_back(plain_row("2", 1'b0));
    table_rows.push_back(plain_row("0", 1'b0));
    table_rows.push_back(typed_row(CH_PERCENT, 1'b1, 1, mk_result(CH_PERCENT, 1'b1, 1'b1),
                                   '0, '0));
    table_rows.push_back(typed_row(8'hFF, 1'b1, 1, mk_result(8'hFF, 1'b1, 1'b1), '0, '0));
    table_rows.push_back(plain_row(CH_PERCENT, 1'b0));
    table_rows.push_back(plain_row("7", 1'b1));

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (table_rows[i]) send_item(table_rows[i]);

    // Phases usually stop part-way through a string, so a new limit often
    // takes effect in the middle of a string.
    for (p = 0; p < 8; p++) begin
      settle();
      write_limit(phase_limit[p]);
      in_idle_on = (p != 3);
      out_idle_on = (p != 3);
      stim_q.delete();
      while (stim_q.size() < 52) add_string();
      for (i = 0; i < 52; i++) send_item(stim_q[i]);
    end

    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("percent_url_decoder: match");
    end else begin
      $display("percent_url_decoder: mismatch");
    end
    $finish;
  end

endmodule

@@ percent_url_decoder.f @@
rtl/pdec_pkg.sv
rtl/pdec_decode.sv
rtl/pdec_emit.sv
rtl/percent_url_decoder.sv
tb/tb_percent_url_decoder.sv
